FILE: design/ofd_pkg.sv
// shared types, constants and codes for the optical flow frame decoder
package ofd_pkg;

   // frame byte codes
   localparam logic [7:0] HDR_BYTE    = 8'hAA;
   localparam logic [7:0] ADDR_BYTE   = 8'hFF;
   localparam logic [7:0] FUNC_A_BYTE = 8'h51;
   localparam logic [7:0] FUNC_B_BYTE = 8'h34;
   localparam logic [3:0] MOTION_LEN  = 4'hF;
   localparam logic [3:0] HEIGHT_LEN  = 4'h7;

   // frame buffer geometry
   localparam int STORE_DEPTH = 21;
   localparam int INDEX_W     = 5;

   // arithmetic widths
   localparam int VALUE_W = 16;
   localparam int GAIN_W  = 16;
   localparam int PROD_W  = VALUE_W + GAIN_W + 1;
   localparam int POS_W   = 48;
   localparam int HEIGHT_W = 8;
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_FIX_X_RESET   = 16'd393;
   localparam logic [GAIN_W-1:0]   GAIN_FIX_Y_RESET   = 16'd393;
   localparam logic [GAIN_W-1:0]   GAIN_SPE_X_RESET   = 16'd328;
   localparam logic [GAIN_W-1:0]   GAIN_SPE_Y_RESET   = 16'd3277;
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT_RESET = 8'd240;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET       = 8'd9;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FIX_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FIX_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SPE_X   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SPE_Y   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_LIMIT = 3'd4;

   // result status codes
   typedef enum logic [1:0] {
      ST_MOTION     = 2'd0,
      ST_HEIGHT_OK  = 2'd1,
      ST_HEIGHT_REJ = 2'd2,
      ST_CHK_ERR    = 2'd3
   } status_type;

   // configuration registers
   typedef struct packed {
      logic [GAIN_W-1:0]   gain_fix_x;
      logic [GAIN_W-1:0]   gain_fix_y;
      logic [GAIN_W-1:0]   gain_spe_x;
      logic [GAIN_W-1:0]   gain_spe_y;
      logic [HEIGHT_W-1:0] height_limit;
   } cfg_type;

   // classified frame handed from front to back
   // motion order: speed_x, speed_y, fix_x, fix_y, dist_x, dist_y
   typedef struct packed {
      status_type                  status;
      logic [5:0][VALUE_W-1:0]     motion;
      logic [HEIGHT_W-1:0]         height;
   } desc_type;

   // one result item
   typedef struct packed {
      status_type                  frame_status;
      logic [5:0][VALUE_W-1:0]     motion;
      logic [3:0][POS_W-1:0]       pos;
      logic [HEIGHT_W-1:0]         height_cm;
   } result_type;

endpackage

FILE: design/ofd_front.sv
// byte parser: hunts frames, runs both checksums, classifies finished frames
module ofd_front import ofd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [7:0]          rx_byte,
   input  logic [HEIGHT_W-1:0] height_limit,
   output logic                push,
   output desc_type            push_desc
);

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_ADDR = 5'b00010,
      PH_FUNC = 5'b00100,
      PH_LEN  = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [3:0]         payload_len_ff, payload_len_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         add_ff, add_in;
   logic [7:0]         store_ff [STORE_DEPTH];

   logic [INDEX_W-1:0] next_index;
   logic [INDEX_W-1:0] end_index;
   logic [INDEX_W-1:0] check_index;
   logic               frame_done;
   logic [7:0]         sum_byte;
   logic               sums_ok;
   logic [31:0]        height_raw;
   logic               height_ok;

   assign next_index  = byte_index_ff + INDEX_W'(1);
   assign end_index   = INDEX_W'(payload_len_ff) + INDEX_W'(6);
   assign check_index = INDEX_W'(payload_len_ff) + INDEX_W'(4);
   assign frame_done  = (phase_ff == PH_BODY) && (next_index == end_index);

   // parser phase and running sums
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      payload_len_in = payload_len_ff;
      sum_in         = sum_ff;
      add_in         = add_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == HDR_BYTE) begin
               sum_in   = rx_byte;
               add_in   = rx_byte;
               phase_in = PH_ADDR;
            end
         end
         PH_ADDR: begin
            if (rx_byte == ADDR_BYTE) begin
               sum_in   = sum_ff + rx_byte;
               add_in   = add_ff + sum_in;
               phase_in = PH_FUNC;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_FUNC: begin
            if (rx_byte == FUNC_A_BYTE || rx_byte == FUNC_B_BYTE) begin
               sum_in   = sum_ff + rx_byte;
               add_in   = add_ff + sum_in;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (rx_byte == {4'h0, MOTION_LEN} || rx_byte == {4'h0, HEIGHT_LEN}) begin
               sum_in         = sum_ff + rx_byte;
               add_in         = add_ff + sum_in;
               payload_len_in = rx_byte[3:0];
               byte_index_in  = INDEX_W'(4);
               phase_in       = PH_BODY;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_BODY: begin
            if (byte_index_ff < check_index) begin
               sum_in = sum_ff + rx_byte;
               add_in = add_ff + sum_in;
            end
            byte_index_in = next_index;
            if (frame_done) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         byte_index_ff  <= '0;
         payload_len_ff <= '0;
         sum_ff         <= '0;
         add_ff         <= '0;
      end else if (byte_accept) begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         payload_len_ff <= payload_len_in;
         sum_ff         <= sum_in;
         add_ff         <= add_in;
      end
   end

   // frame body bytes, kept at their position in the frame
   always_ff @(posedge clock) begin
      if (byte_accept && phase_ff == PH_BODY && byte_index_ff < INDEX_W'(STORE_DEPTH)) begin
         store_ff[byte_index_ff] <= rx_byte;
      end
   end

   // checks: sum byte is already stored, running-sum byte is the current one
   assign sum_byte = (payload_len_ff == MOTION_LEN) ? store_ff[19] : store_ff[11];
   assign sums_ok  = (sum_ff == sum_byte) && (add_ff == rx_byte);

   // height accepted only for 0 < h < limit as a signed 32-bit value
   assign height_raw = {store_ff[10], store_ff[9], store_ff[8], store_ff[7]};
   assign height_ok  = (height_raw[31:HEIGHT_W] == '0) && (height_raw[HEIGHT_W-1:0] != '0)
                       && (height_raw[HEIGHT_W-1:0] < height_limit);

   // classified frame into the queue
   always_comb begin
      push_desc.motion = '0;
      for (int k = 0; k < 6; k++) begin
         push_desc.motion[k] = {store_ff[7 + 2 * k], store_ff[6 + 2 * k]};
      end
      push_desc.height = height_raw[HEIGHT_W-1:0];
      priority if (!sums_ok) begin
         push_desc.status = ST_CHK_ERR;
      end else if (payload_len_ff == MOTION_LEN) begin
         push_desc.status = ST_MOTION;
      end else if (height_ok) begin
         push_desc.status = ST_HEIGHT_OK;
      end else begin
         push_desc.status = ST_HEIGHT_REJ;
      end
   end

   assign push = byte_accept && frame_done;

endmodule

FILE: design/ofd_queue.sv
// short frame queue between parser and back end
module ofd_queue import ofd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output desc_type pop_desc
);

   // depth is a power of two so the pointers wrap on their own
   desc_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: design/ofd_back.sv
// back end: gain products, position accumulation, result register
module ofd_back import ofd_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  desc_type   q_desc,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data
);

   localparam int SH_R = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
   localparam int SH_L = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;

   logic                     m_valid_ff;
   desc_type                 m_desc_ff;
   logic signed [PROD_W-1:0] m_prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic [VALUE_W-1:0]       mul_value [4];
   logic [GAIN_W-1:0]        mul_gain [4];

   logic [5:0][VALUE_W-1:0]  motion_ff, motion_in;
   logic [3:0][POS_W-1:0]    pos_ff, pos_in;
   logic [HEIGHT_W-1:0]      height_ff, height_in;
   logic                     rsp_valid_ff;
   result_type               rsp_ff;
   logic signed [POS_W-1:0]  inc [4];

   logic out_free;
   logic m_adv;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign m_adv    = m_valid_ff && out_free;
   assign pop      = !q_empty && (!m_valid_ff || out_free);

   // product operands: fix into the first pair of sums, speed into the second
   always_comb begin
      mul_value[0] = q_desc.motion[2];
      mul_value[1] = q_desc.motion[3];
      mul_value[2] = q_desc.motion[0];
      mul_value[3] = q_desc.motion[1];
      mul_gain[0]  = cfg.gain_fix_x;
      mul_gain[1]  = cfg.gain_fix_y;
      mul_gain[2]  = cfg.gain_spe_x;
      mul_gain[3]  = cfg.gain_spe_y;
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = PROD_W'($signed(mul_value[k]) * $signed({1'b0, mul_gain[k]}));
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (pop) begin
         m_valid_ff <= 1'b1;
      end else if (m_adv) begin
         m_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_desc_ff <= q_desc;
         for (int k = 0; k < 4; k++) begin
            m_prod_ff[k] <= prod_in[k];
         end
      end
   end

   // increments at 16 fraction bits, then state update per frame kind
   always_comb begin
      motion_in = motion_ff;
      pos_in    = pos_ff;
      height_in = height_ff;
      for (int k = 0; k < 4; k++) begin
         inc[k] = ($signed({{(POS_W - PROD_W){m_prod_ff[k][PROD_W-1]}}, m_prod_ff[k]})
                   >>> SH_R) <<< SH_L;
      end
      unique case (m_desc_ff.status)
         ST_MOTION: begin
            motion_in = m_desc_ff.motion;
            for (int k = 0; k < 4; k++) begin
               pos_in[k] = pos_ff[k] + inc[k];
            end
         end
         ST_HEIGHT_OK: begin
            height_in = m_desc_ff.height;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= '0;
         pos_ff    <= '0;
         height_ff <= HEIGHT_RESET;
      end else if (m_adv) begin
         motion_ff <= motion_in;
         pos_ff    <= pos_in;
         height_ff <= height_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (m_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (m_adv) begin
         rsp_ff.frame_status <= m_desc_ff.status;
         rsp_ff.motion       <= motion_in;
         rsp_ff.pos          <= pos_in;
         rsp_ff.height_cm    <= height_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/optical_flow_frame_decoder.sv
// optical flow frame decoder: one received byte per cycle, one result per finished frame
// throughput: one byte per cycle; the parser stalls only when the two-entry queue is full
// path: the result of a frame is registered in turn in the queue entry, the gain product
//   register and the result register, after the edge that takes the last frame byte
// reset: synchronous, active high; clears parser, queue, sums to zero, height to 9,
//   and loads the register reset values; no clearing pass
module optical_flow_frame_decoder import ofd_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_frame_status,
   output logic signed [VALUE_W-1:0] rsp_speed_x,
   output logic signed [VALUE_W-1:0] rsp_speed_y,
   output logic signed [VALUE_W-1:0] rsp_fix_x,
   output logic signed [VALUE_W-1:0] rsp_fix_y,
   output logic signed [VALUE_W-1:0] rsp_dist_x,
   output logic signed [VALUE_W-1:0] rsp_dist_y,
   output logic signed [POS_W-1:0]   rsp_pos_fix_x,
   output logic signed [POS_W-1:0]   rsp_pos_fix_y,
   output logic signed [POS_W-1:0]   rsp_pos_spe_x,
   output logic signed [POS_W-1:0]   rsp_pos_spe_y,
   output logic [HEIGHT_W-1:0]       rsp_height_cm,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [GAIN_W-1:0]         csr_data
);

   cfg_type    cfg_ff;
   logic       byte_accept;
   logic       q_push;
   desc_type   q_push_desc;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   desc_type   q_pop_desc;
   result_type rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_fix_x   <= GAIN_FIX_X_RESET;
         cfg_ff.gain_fix_y   <= GAIN_FIX_Y_RESET;
         cfg_ff.gain_spe_x   <= GAIN_SPE_X_RESET;
         cfg_ff.gain_spe_y   <= GAIN_SPE_Y_RESET;
         cfg_ff.height_limit <= HEIGHT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAIN_FIX_X:   cfg_ff.gain_fix_x   <= csr_data;
            CSR_GAIN_FIX_Y:   cfg_ff.gain_fix_y   <= csr_data;
            CSR_GAIN_SPE_X:   cfg_ff.gain_spe_x   <= csr_data;
            CSR_GAIN_SPE_Y:   cfg_ff.gain_spe_y   <= csr_data;
            CSR_HEIGHT_LIMIT: cfg_ff.height_limit <= csr_data[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input transfer
   assign req_stall   = q_full;
   assign byte_accept = req_valid && !req_stall;

   ofd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_rx_byte),
      .height_limit (cfg_ff.height_limit),
      .push         (q_push),
      .push_desc    (q_push_desc)
   );

   ofd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_desc  (q_pop_desc)
   );

   ofd_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_desc    (q_pop_desc),
      .pop       (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // result fields
   assign rsp_frame_status = rsp_data.frame_status;
   assign rsp_speed_x      = rsp_data.motion[0];
   assign rsp_speed_y      = rsp_data.motion[1];
   assign rsp_fix_x        = rsp_data.motion[2];
   assign rsp_fix_y        = rsp_data.motion[3];
   assign rsp_dist_x       = rsp_data.motion[4];
   assign rsp_dist_y       = rsp_data.motion[5];
   assign rsp_pos_fix_x    = rsp_data.pos[0];
   assign rsp_pos_fix_y    = rsp_data.pos[1];
   assign rsp_pos_spe_x    = rsp_data.pos[2];
   assign rsp_pos_spe_y    = rsp_data.pos[3];
   assign rsp_height_cm    = rsp_data.height_cm;

   // a finished frame never meets a full queue
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("frame pushed into full queue");

   // the back end only takes from a filled queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // an accepted height is never zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status == ST_HEIGHT_OK) |-> (rsp_height_cm != '0))
      else $error("accepted height of zero");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
